// ----- src/brb_pkg.sv -----
// Shared types, constants and helpers of the byte ring buffer.
package brb_pkg;

  // Store geometry and burst limit.
  localparam int STORE_DEPTH = 4096;
  localparam int MAX_BURST   = 64;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SIZE_W      = ADDR_W + 1;
  localparam int BURST_W     = $clog2(MAX_BURST + 1);

  // Fixed field widths of the channels.
  localparam int BYTE_W   = 8;
  localparam int BLEN_W   = 7;
  localparam int CNT_W    = 12;
  localparam int CFG_W    = 13;
  localparam int MIN_SIZE = 2;

  // Operation codes carried on the input tuser.
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_PEEK  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  // Configuration seen by the core: clamped ring size and a clear pulse.
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              clear;
  } brb_cfg_t;

  // One result as held in the output register.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              write_accepted;
    logic              last;
    logic [CNT_W-1:0]  bytes_used;
    logic [CNT_W-1:0]  bytes_free;
  } brb_result_t;

  // Keeps the low count bits of a size-wide value, zero extended if narrower.
  function automatic logic [CNT_W-1:0] to_cnt(input logic [SIZE_W-1:0] v);
    logic [SIZE_W+CNT_W-1:0] wide;
    wide = {{CNT_W{1'b0}}, v};
    return wide[CNT_W-1:0];
  endfunction

endpackage

// ----- src/byte_ring_buffer_unit.sv -----
// Top level of the byte ring buffer: size register, channel packing and core.
//
//  Channel | Direction | Transfer when          | Carries
//  in_     | slave     | in_tvalid & in_tready  | kind, data byte, burst length
//  out_    | master    | out_tvalid & out_tready| byte, flags, last, used/free
//  cfg_    | write     | cfg_wen                | ring size in bytes
//
//  A write's result is registered at the transfer edge.
//  A read or peek of n bytes starts with a store read, then gives one byte per
//  cycle unless the output stalls, via the store's single registered read port.
//  Reset sets the ring size to the store depth and empties the buffer; no
//  clearing pass is needed. A size write empties the buffer at its own edge and
//  holds the input off in that cycle. A stalled output holds the sequencer in place.
module byte_ring_buffer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [12:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [14:8] burst_length, [15] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [19:8] bytes_used, [31:20] bytes_free
  output logic [1:0]  out_tuser,  // [0] byte_valid, [1] write_accepted
  output logic        out_tlast
);
  import brb_pkg::*;

  logic [SIZE_W-1:0] size_r, size_nxt;
  brb_cfg_t          cfg;
  brb_result_t       result;

  // Size written by configuration, clamped to the supported range.
  always_comb begin
    priority if (cfg_wdata < CFG_W'(MIN_SIZE)) begin
      size_nxt = SIZE_W'(MIN_SIZE);
    end else if (SIZE_W'(cfg_wdata) > SIZE_W'(STORE_DEPTH) ||
                 (CFG_W > SIZE_W && (cfg_wdata >> SIZE_W) != '0)) begin
      size_nxt = SIZE_W'(STORE_DEPTH);
    end else begin
      size_nxt = SIZE_W'(cfg_wdata);
    end
  end

  // Size register; the core empties the ring at the same edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(STORE_DEPTH);
    end else if (cfg_wen) begin
      size_r <= size_nxt;
    end
  end

  assign cfg.size  = size_r;
  assign cfg.clear = cfg_wen;

  brb_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .kind         (kind_t'(in_tuser)),
    .data_byte    (in_tdata[7:0]),
    .burst_length (in_tdata[14:8]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .result       (result)
  );

  // Result packing onto the master side.
  assign out_tdata = {result.bytes_free, result.bytes_used, result.out_byte};
  assign out_tuser = {result.write_accepted, result.byte_valid};
  assign out_tlast = result.last;

endmodule

// ----- src/brb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when not enabled.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/brb_core.sv -----
// Ring buffer sequencer: positions, fill count, store access and result register.
module brb_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  brb_pkg::brb_cfg_t           cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  brb_pkg::kind_t              kind,
  input  logic [brb_pkg::BYTE_W-1:0]  data_byte,
  input  logic [brb_pkg::BLEN_W-1:0]  burst_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output brb_pkg::brb_result_t        result
);
  import brb_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  rd_pos_r, rd_pos_nxt;
  logic [ADDR_W-1:0]  wr_pos_r, wr_pos_nxt;
  logic [ADDR_W-1:0]  pos_r, pos_nxt;
  logic [ADDR_W-1:0]  used_r, used_nxt;
  logic [BURST_W-1:0] rem_r, rem_nxt;
  logic               peek_r, peek_nxt;
  logic               out_valid_r, out_valid_nxt;
  brb_result_t        result_r, result_nxt;

  logic               slot_free;
  logic               accept;
  logic               load;
  logic [BURST_W-1:0] burst_cut;
  logic [BURST_W-1:0] burst_n;
  logic               ram_we;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;
  logic [SIZE_W-1:0]  cap;

  // Next slot around the ring of the configured size.
  function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] p,
                                                  input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] inc;
    inc = SIZE_W'(p) + SIZE_W'(1);
    return (inc >= s) ? '0 : inc[ADDR_W-1:0];
  endfunction

  brb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_pos_r),
    .wdata (data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cap       = cfg.size - SIZE_W'(1);
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free && !cfg.clear;
  assign accept    = in_valid && in_ready;

  // Burst length cut to the burst limit, then to the bytes held.
  assign burst_cut = (burst_length > BLEN_W'(MAX_BURST)) ? BURST_W'(MAX_BURST)
                                                         : BURST_W'(burst_length);
  assign burst_n   = (SIZE_W'(used_r) < SIZE_W'(burst_cut)) ? BURST_W'(used_r)
                                                            : burst_cut;

  // Sequencer: one write or one byte of a burst per cycle while the output is not stalled.
  always_comb begin
    state_nxt  = state_r;
    rd_pos_nxt = rd_pos_r;
    wr_pos_nxt = wr_pos_r;
    pos_nxt    = pos_r;
    used_nxt   = used_r;
    rem_nxt    = rem_r;
    peek_nxt   = peek_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = rd_pos_r;
    load       = 1'b0;
    result_nxt = result_r;
    result_nxt.out_byte       = '0;
    result_nxt.byte_valid     = 1'b0;
    result_nxt.write_accepted = 1'b0;
    result_nxt.last           = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_WRITE: begin
              load = 1'b1;
              if (SIZE_W'(used_r) < cap) begin
                ram_we     = 1'b1;
                wr_pos_nxt = ring_next(wr_pos_r, cfg.size);
                used_nxt   = used_r + ADDR_W'(1);
                result_nxt.write_accepted = 1'b1;
              end
            end
            KIND_READ, KIND_PEEK: begin
              if (burst_n == '0) begin
                load = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = rd_pos_r;
                pos_nxt   = ring_next(rd_pos_r, cfg.size);
                rem_nxt   = burst_n;
                peek_nxt  = (kind == KIND_PEEK);
                state_nxt = ST_BURST;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_BURST: begin
        if (slot_free) begin
          load = 1'b1;
          result_nxt.out_byte   = ram_rdata;
          result_nxt.byte_valid = 1'b1;
          result_nxt.last       = (rem_r == BURST_W'(1));
          if (!peek_r) begin
            used_nxt   = used_r - ADDR_W'(1);
            rd_pos_nxt = pos_r;
          end
          if (rem_r == BURST_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = pos_r;
            pos_nxt   = ring_next(pos_r, cfg.size);
            rem_nxt   = rem_r - BURST_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Counts in every result are those after the result's effect.
    result_nxt.bytes_used = to_cnt(SIZE_W'(used_nxt));
    result_nxt.bytes_free = to_cnt(cap - SIZE_W'(used_nxt));

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // State, positions, fill count and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pos_r    <= '0;
      wr_pos_r    <= '0;
      pos_r       <= '0;
      used_r      <= '0;
      rem_r       <= '0;
      peek_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (cfg.clear) begin
      state_r     <= ST_IDLE;
      rd_pos_r    <= '0;
      wr_pos_r    <= '0;
      used_r      <= '0;
      out_valid_r <= out_valid_nxt;
    end else begin
      state_r     <= state_nxt;
      rd_pos_r    <= rd_pos_nxt;
      wr_pos_r    <= wr_pos_nxt;
      pos_r       <= pos_nxt;
      used_r      <= used_nxt;
      rem_r       <= rem_nxt;
      peek_r      <= peek_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

  // The fill count never exceeds the usable capacity.
  a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
    SIZE_W'(used_r) <= cap)
    else $error("fill count above capacity");

  // A burst always has bytes left to deliver.
  a_burst_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BURST) |-> (rem_r != '0))
    else $error("burst with no bytes remaining");

  // The store is never written during a burst.
  a_no_write_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BURST) |-> !ram_we)
    else $error("store write during burst");

  // A result waiting on a stalled output is not overwritten.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !load)
    else $error("result register overwritten while stalled");

endmodule
